>>> hw/rtl/spwt_pkg.sv
// ---------------------------------------------------------------------------
// spwt_pkg
// shared types and codes of the syscall/process watch table
// ---------------------------------------------------------------------------
package spwt_pkg;

    // operation codes carried in the op field
    typedef enum logic [2:0] {
        OP_ADD       = 3'd0,
        OP_DROP_PROC = 3'd1,
        OP_DROP_PAIR = 3'd2,
        OP_PURGE     = 3'd3,
        OP_LOOKUP    = 3'd4
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } state_t;

    // token that walks the cell chain, one cell per cycle
    typedef struct packed {
        logic active;
        logic hit;      // some earlier cell matched the query
        logic placed;   // some earlier cell can take the new entry
    } tok_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic [2:0] op;
        logic       apply;  // update slot state this cycle
        logic       hit;    // final match result of the scan
    } ctl_t;

endpackage

>>> hw/rtl/spwt_req_if.sv
// ---------------------------------------------------------------------------
// spwt_req_if
// request channel: operation, call number and process id
// ---------------------------------------------------------------------------
interface spwt_req_if #(
    parameter int CALL_BITS    = 9,
    parameter int PROCESS_BITS = 22
);
    logic                    valid;
    logic                    ready;
    logic [2:0]              op;
    logic [CALL_BITS-1:0]    call_number;
    logic [PROCESS_BITS-1:0] process_id;

    modport source (output valid, output op, output call_number, output process_id,
                    input ready);
    modport sink   (input valid, input op, input call_number, input process_id,
                    output ready);
endinterface

>>> hw/rtl/spwt_rsp_if.sv
// ---------------------------------------------------------------------------
// spwt_rsp_if
// response channel: found flag and status
// ---------------------------------------------------------------------------
interface spwt_rsp_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [1:0] status;

    modport source (output valid, output found, output status, input ready);
    modport sink   (input valid, input found, input status, output ready);
endinterface

>>> hw/rtl/spwt_cell.sv
// ---------------------------------------------------------------------------
// spwt_cell
// one table slot: compares against the query as the token passes and
// applies the broadcast update at commit
// ---------------------------------------------------------------------------
module spwt_cell #(
    parameter int CALL_BITS    = 9,
    parameter int PROCESS_BITS = 22
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [CALL_BITS-1:0]    q_call,
    input  logic [PROCESS_BITS-1:0] q_proc,
    input  spwt_pkg::ctl_t          ctl,
    input  spwt_pkg::tok_t          tok_in,
    output spwt_pkg::tok_t          tok_out
);

    logic                    valid_reg;
    logic                    valid_next;
    logic                    chosen_reg;
    logic                    chosen_next;
    logic                    write_en;
    logic [CALL_BITS-1:0]    call_reg;
    logic [PROCESS_BITS-1:0] proc_reg;
    spwt_pkg::tok_t          tok_reg;
    spwt_pkg::tok_t          tok_next;

    logic call_eq;
    logic wild;
    logic match;
    logic freeable;

    assign call_eq  = valid_reg && (call_reg == q_call);
    assign wild     = (q_proc == '0);
    assign match    = call_eq && ((proc_reg == q_proc) || (proc_reg == '0));
    // free now, or freed by a wildcard add of the same call
    assign freeable = !valid_reg || (wild && call_eq);

    always_comb
    begin
        tok_next    = '0;
        chosen_next = chosen_reg;
        if (tok_in.active)
        begin
            tok_next.active = 1'b1;
            tok_next.hit    = tok_in.hit | match;
            tok_next.placed = tok_in.placed | freeable;
            chosen_next     = !tok_in.placed && freeable;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        write_en   = 1'b0;
        if (ctl.apply)
        begin
            case (ctl.op)
                spwt_pkg::OP_ADD:
                begin
                    if (!ctl.hit)
                    begin
                        if (chosen_reg)
                        begin
                            valid_next = 1'b1;
                            write_en   = 1'b1;
                        end
                        else if (wild && call_eq)
                        begin
                            valid_next = 1'b0;
                        end
                    end
                end
                spwt_pkg::OP_DROP_PROC:
                begin
                    if (proc_reg == q_proc)
                    begin
                        valid_next = 1'b0;
                    end
                end
                spwt_pkg::OP_DROP_PAIR:
                begin
                    if (match)
                    begin
                        valid_next = 1'b0;
                    end
                end
                spwt_pkg::OP_PURGE:
                begin
                    valid_next = 1'b0;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            chosen_reg <= 1'b0;
            tok_reg    <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            chosen_reg <= chosen_next;
            tok_reg    <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            call_reg <= q_call;
            proc_reg <= q_proc;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> hw/rtl/syscall_pid_watch_table_unit.sv
// ---------------------------------------------------------------------------
// syscall_pid_watch_table_unit
// table of (call number, process id) watch entries built as a chain of
// slot cells; process id 0 in an entry matches every process
// ---------------------------------------------------------------------------
//
//  channel  dir  beat contents                     handshake
//  -------  ---  --------------------------------  -----------
//  req      in   op, call_number, process_id       valid/ready
//  rsp      out  found, status                     valid/ready
//
// every operation is a scan followed by a commit before the next accept:
// a token walks the cell chain one slot per cycle, gathering the
// match and the lowest usable slot, then the commit updates all slots
// reset empties the table at once; no clearing pass
// a stalled rsp holds the commit until the output register frees up; req is
// taken again as soon as the commit is done, even while a result still waits
//
module syscall_pid_watch_table_unit #(
    parameter int TABLE_SLOTS  = 64,
    parameter int CALL_BITS    = 9,
    parameter int PROCESS_BITS = 22
) (
    input  logic       clk,
    input  logic       rst_n,
    spwt_req_if.sink   req,
    spwt_rsp_if.source rsp
);

    // sequencer
    spwt_pkg::state_t state_reg;
    spwt_pkg::state_t state_next;

    // operation held for the whole scan, broadcast to the cells
    logic [2:0]              op_reg;
    logic [2:0]              op_next;
    logic [CALL_BITS-1:0]    call_reg;
    logic [CALL_BITS-1:0]    call_next;
    logic [PROCESS_BITS-1:0] proc_reg;
    logic [PROCESS_BITS-1:0] proc_next;

    // token launch into the head of the chain
    logic launch_reg;
    logic launch_next;

    // scan results taken from the tail of the chain
    logic hit_reg;
    logic hit_next;
    logic placed_reg;
    logic placed_next;

    // output register
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       found_reg;
    logic       found_next;
    logic [1:0] status_reg;
    logic [1:0] status_next;

    logic           out_free;
    logic           in_fire;
    spwt_pkg::ctl_t ctl;
    spwt_pkg::tok_t tok [0:TABLE_SLOTS];

    assign out_free = !out_valid_reg || rsp.ready;
    assign in_fire  = req.valid && req.ready;

    // head token: fresh scan, nothing seen yet
    always_comb
    begin
        tok[0]        = '0;
        tok[0].active = launch_reg;
    end

    // the chain of slots
    for (genvar i = 0; i < TABLE_SLOTS; i++)
    begin : g_cell
        spwt_cell #(
            .CALL_BITS    (CALL_BITS),
            .PROCESS_BITS (PROCESS_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .q_call  (call_reg),
            .q_proc  (proc_reg),
            .ctl     (ctl),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        call_next      = call_reg;
        proc_next      = proc_reg;
        launch_next    = 1'b0;
        hit_next       = hit_reg;
        placed_next    = placed_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        found_next     = found_reg;
        status_next    = status_reg;
        req.ready      = 1'b0;
        ctl.op         = op_reg;
        ctl.hit        = hit_reg;
        ctl.apply      = 1'b0;

        case (state_reg)
            spwt_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
                if (in_fire)
                begin
                    op_next     = req.op;
                    call_next   = req.call_number;
                    proc_next   = req.process_id;
                    launch_next = 1'b1;
                    state_next  = spwt_pkg::S_SCAN;
                end
            end
            spwt_pkg::S_SCAN:
            begin
                // token reached the tail: match and slot search complete
                if (tok[TABLE_SLOTS].active)
                begin
                    hit_next    = tok[TABLE_SLOTS].hit;
                    placed_next = tok[TABLE_SLOTS].placed;
                    state_next  = spwt_pkg::S_COMMIT;
                end
            end
            spwt_pkg::S_COMMIT:
            begin
                if (out_free)
                begin
                    ctl.apply      = 1'b1;
                    out_valid_next = 1'b1;
                    found_next     = 1'b0;
                    status_next    = spwt_pkg::ST_DONE;
                    if (op_reg == spwt_pkg::OP_ADD)
                    begin
                        found_next = hit_reg;
                        if (hit_reg)
                        begin
                            status_next = spwt_pkg::ST_DUP;
                        end
                        else if (!placed_reg)
                        begin
                            status_next = spwt_pkg::ST_FULL;
                        end
                    end
                    else if (op_reg == spwt_pkg::OP_LOOKUP)
                    begin
                        found_next = hit_reg;
                    end
                    state_next = spwt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spwt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spwt_pkg::S_IDLE;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        call_reg   <= call_next;
        proc_reg   <= proc_next;
        hit_reg    <= hit_next;
        placed_reg <= placed_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.found  = found_reg;
    assign rsp.status = status_reg;

endmodule

>>> hw/rtl/spwt_checker.sv
// ---------------------------------------------------------------------------
// spwt_checker
// port-level checks of the watch table, attached by bind
// ---------------------------------------------------------------------------
module spwt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       rsp_found,
    input logic [1:0] rsp_status
);

    // a waiting result beat holds its value
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_status))
        else $error("rsp beat changed while stalled");

    // one operation at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req taken while an operation is in flight");

    // duplicate add always reports a found entry
    a_dup_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == spwt_pkg::ST_DUP) |-> rsp_found)
        else $error("duplicate status without found");

    // full table means no match was found, and no unused status code
    a_full_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == spwt_pkg::ST_DONE || rsp_status == spwt_pkg::ST_DUP ||
                       rsp_status == spwt_pkg::ST_FULL) &&
                      !((rsp_status == spwt_pkg::ST_FULL) && rsp_found))
        else $error("bad status on rsp");

endmodule

bind syscall_pid_watch_table_unit spwt_checker u_spwt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_found  (rsp.found),
    .rsp_status (rsp.status)
);
